/* rtl/ipbl_pkg.sv */
// Shared types, codes and constants of the IPv4 blacklist table.
package ipbl_pkg;

	localparam int LIST_DEPTH_DEF = 64;

	localparam int FUNC_W   = 2;
	localparam int ADDR_W   = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOKUP = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_DEL_RD,
		S_DEL_WR,
		S_SCAN,
		S_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic decide;
		logic do_insert;
		logic shift_start;
		logic shift_rd;
		logic shift_wr;
		logic shift_end;
		logic scan_start;
		logic scan_step;
		logic publish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              pos_bad;
		logic              shift_more;
		logic              scan_done;
	} sts_t;

endpackage

/* rtl/ipbl_dp.sv */
// Datapath of the IPv4 blacklist table: list memory, fill count, pointers, result registers.
module ipbl_dp import ipbl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ADDR_W-1:0]   address,
	input  logic [POS_W-1:0]    position,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic [STATUS_W-1:0] status,
	output logic                blocked,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [FUNC_W-1:0]  func_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W:0]     idx_inc;
	logic [CMP_W-1:0]   fill_ext;
	logic [CMP_W-1:0]   pos_ext;
	logic [ADDR_W-1:0]  mem [LIST_DEPTH];
	logic [ADDR_W-1:0]  rdata_s1;
	logic               rd_vld_s1;
	logic               hit_q;
	status_t            res_status_q;
	status_t            res_status_n;
	status_t            status_q;
	logic               blocked_q;
	logic [COUNT_W-1:0] count_q;
	logic               scan_rd;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]  wr_data;
	logic               wr_en;

	assign idx_inc  = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
	assign fill_ext = CMP_W'(fill_q);
	assign pos_ext  = CMP_W'(pos_q);

	assign sts.func       = func_q;
	assign sts.full       = (fill_q == CNT_W'(LIST_DEPTH));
	assign sts.pos_bad    = (pos_q == '0) || (pos_ext > fill_ext);
	assign sts.shift_more = (idx_inc < {1'b0, fill_q});
	assign sts.scan_done  = (idx_q >= fill_q) && !rd_vld_s1;

	assign scan_rd = cmd.scan_step && (idx_q < fill_q);
	assign rd_addr = cmd.shift_rd ? idx_inc[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wr_en   = cmd.do_insert || cmd.shift_wr;
	assign wr_addr = cmd.do_insert ? fill_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wr_data = cmd.do_insert ? addr_q : rdata_s1;

	always_comb begin
		res_status_n = ST_DONE;
		if ((func_q == FUNC_INSERT) && sts.full) begin
			res_status_n = ST_FULL;
		end else if ((func_q == FUNC_DELETE) && sts.pos_bad) begin
			res_status_n = ST_BADPOS;
		end
	end

	// list memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_rd;
			if (cmd.do_insert) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.shift_end) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			addr_q <= address;
			pos_q  <= position;
		end
		if (cmd.decide) begin
			res_status_q <= res_status_n;
		end
		if (cmd.shift_start) begin
			idx_q <= CNT_W'(pos_ext - CMP_W'(1));
		end else if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.shift_wr || scan_rd) begin
			idx_q <= idx_inc[CNT_W-1:0];
		end
		if (cmd.scan_start) begin
			hit_q <= 1'b0;
		end else if (rd_vld_s1 && (rdata_s1 == addr_q)) begin
			hit_q <= 1'b1;
		end
		if (cmd.publish) begin
			status_q  <= res_status_q;
			blocked_q <= (func_q == FUNC_LOOKUP) && hit_q;
			count_q   <= fill_ext[COUNT_W-1:0];
		end
	end

	assign status      = status_q;
	assign blocked     = blocked_q;
	assign entry_count = count_q;

endmodule

/* rtl/ipbl_ctrl.sv */
// Controller of the IPv4 blacklist table: operation sequencer and result valid.
module ipbl_ctrl import ipbl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				unique case (sts.func)
					FUNC_INSERT: begin
						cmd.do_insert = !sts.full;
						state_n       = S_FIN;
					end
					FUNC_DELETE: begin
						if (sts.pos_bad) begin
							state_n = S_FIN;
						end else begin
							cmd.shift_start = 1'b1;
							state_n         = S_DEL_RD;
						end
					end
					FUNC_LOOKUP: begin
						cmd.scan_start = 1'b1;
						state_n        = S_SCAN;
					end
					default: begin
						state_n = S_FIN;
					end
				endcase
			end
			S_DEL_RD: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_n      = S_DEL_WR;
				end else begin
					cmd.shift_end = 1'b1;
					state_n       = S_FIN;
				end
			end
			S_DEL_WR: begin
				cmd.shift_wr = 1'b1;
				state_n      = S_DEL_RD;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/ipv4_blacklist_table_unit.sv */
// Top level of the IPv4 blacklist table: controller plus datapath.
//
// Ordered list of up to LIST_DEPTH blocked IPv4 addresses held in a single-port-write,
// registered-read memory. One transaction at a time is processed. func selects the
// operation: insert appends address (status full when the list is full, no duplicate
// check), delete removes the entry at 1-based position and moves the later entries down
// (status bad position for position 0 or past the last entry), lookup sets blocked when
// address matches any listed entry. Code 3 does nothing and reports done. Every input
// transaction yields exactly one result with the entry count after the operation (low
// 7 bits of it). A result that is ready to publish waits while the previous result is
// still held by a low out_ready. All passes are paced by the one read port of the list
// memory: a lookup reads one entry per cycle, a delete moves each entry by a read, then
// a write back one place lower. The result sits in an output register, so a new
// transaction is taken as soon as the previous result has been registered, even while
// that result still waits for out_ready. No clearing pass after reset; the list starts
// empty.
module ipv4_blacklist_table_unit import ipbl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ADDR_W-1:0]   address,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                blocked,
	output logic [COUNT_W-1:0]  entry_count
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, decide, shift or scan passes, publish
	ipbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// list storage, pointers and result registers
	ipbl_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.address     (address),
		.position    (position),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.blocked     (blocked),
		.entry_count (entry_count)
	);

endmodule

/* rtl/ipbl_chk.sv */
// Port-level checker for the IPv4 blacklist table, bound to the top level.
module ipbl_chk import ipbl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic                blocked,
	input logic [COUNT_W-1:0]  entry_count
);

	// one transaction at a time: the block is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on two consecutive cycles");

	// a hit is only reported by a completed lookup
	a_blocked_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && blocked) |-> (status == ST_DONE))
		else $error("blocked set with non-done status");

	// a refused insert means the list is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> (entry_count == COUNT_W'(LIST_DEPTH)))
		else $error("full status with count below capacity");

	// count never above capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((LIST_DEPTH > 127) || (entry_count <= COUNT_W'(LIST_DEPTH))))
		else $error("entry count above list depth");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(status) && $stable(blocked) && $stable(entry_count)))
		else $error("result changed while stalled");

endmodule

bind ipv4_blacklist_table_unit ipbl_chk #(
	.LIST_DEPTH (LIST_DEPTH)
) u_ipbl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.blocked     (blocked),
	.entry_count (entry_count)
);

/* dv/testbench.sv */
// Self-checking testbench for the IPv4 blacklist table: directed table, then random traffic.
module testbench;
	import ipbl_pkg::*;

	// Operation code 3 has no enum member; the block must ignore it.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 250;
	// Worst result latency: a delete at position 1 of a full list.
	localparam int WORST_LATENCY = 2 * LIST_DEPTH_DEF + 16;

	typedef struct packed {
		status_t              status;
		logic                 blocked;
		logic [COUNT_W-1:0]   count;
	} list_result_t;

	// One row of the directed table. When typed is set, the expectation is the one
	// written in the row; otherwise the mirror list computes it.
	typedef struct packed {
		logic [FUNC_W-1:0]  fn;
		logic [ADDR_W-1:0]  addr;
		logic [POS_W-1:0]   pos;
		bit                 typed;
		status_t            st;
		logic               hit;
		logic [COUNT_W-1:0] cnt;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] address;
	logic [POS_W-1:0] position;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic blocked;
	logic [COUNT_W-1:0] entry_count;

	ipv4_blacklist_table_unit #(
		.LIST_DEPTH(LIST_DEPTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.address(address),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.blocked(blocked),
		.entry_count(entry_count)
	);

	// 4-unit clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the list contents, kept in step with every accepted transaction.
	logic [ADDR_W-1:0] mirror_list [LIST_DEPTH_DEF];
	int mirror_fill = 0;
	list_result_t pending_results [$];

	// Idle rates in percent, changed per phase.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit grow = 1'b1;

	int mismatches = 0;
	int results_seen = 0;
	int n_insert = 0, n_full = 0, n_delete = 0, n_badpos = 0;
	int n_lookup = 0, n_hit = 0, n_unused = 0, n_max_fill = 0;

	// Directed table. Counts follow the list as it is built up and torn down.
	stim_row_t dir_rows [19] = '{
		// empty list after reset
		'{FUNC_LOOKUP, 32'h0000_0000, 7'd0,   1'b1, ST_DONE,   1'b0, 7'd0},
		'{FUNC_DELETE, 32'h0000_0000, 7'd1,   1'b1, ST_BADPOS, 1'b0, 7'd0},
		'{FUNC_DELETE, 32'hFFFF_FFFF, 7'd0,   1'b1, ST_BADPOS, 1'b0, 7'd0},
		'{FUNC_UNUSED, 32'h0000_0000, 7'd0,   1'b1, ST_DONE,   1'b0, 7'd0},
		// address extremes, plus a duplicate
		'{FUNC_INSERT, 32'h0000_0000, 7'd127, 1'b1, ST_DONE,   1'b0, 7'd1},
		'{FUNC_INSERT, 32'hFFFF_FFFF, 7'd0,   1'b1, ST_DONE,   1'b0, 7'd2},
		'{FUNC_INSERT, 32'hC0A8_0001, 7'd0,   1'b1, ST_DONE,   1'b0, 7'd3},
		'{FUNC_INSERT, 32'hC0A8_0001, 7'd0,   1'b1, ST_DONE,   1'b0, 7'd4},
		'{FUNC_LOOKUP, 32'hFFFF_FFFF, 7'd127, 1'b1, ST_DONE,   1'b1, 7'd4},
		'{FUNC_LOOKUP, 32'h0000_0000, 7'd0,   1'b1, ST_DONE,   1'b1, 7'd4},
		'{FUNC_LOOKUP, 32'h7FFF_FFFF, 7'd0,   1'b1, ST_DONE,   1'b0, 7'd4},
		// positions past the end and at the top of the field
		'{FUNC_DELETE, 32'h0000_0000, 7'd127, 1'b1, ST_BADPOS, 1'b0, 7'd4},
		'{FUNC_DELETE, 32'h0000_0000, 7'd5,   1'b1, ST_BADPOS, 1'b0, 7'd4},
		// delete the last entry, then the first
		'{FUNC_DELETE, 32'h0000_0000, 7'd4,   1'b1, ST_DONE,   1'b0, 7'd3},
		'{FUNC_LOOKUP, 32'hC0A8_0001, 7'd0,   1'b0, ST_DONE,   1'b0, 7'd0},
		'{FUNC_DELETE, 32'hFFFF_FFFF, 7'd1,   1'b1, ST_DONE,   1'b0, 7'd2},
		'{FUNC_LOOKUP, 32'h0000_0000, 7'd0,   1'b0, ST_DONE,   1'b0, 7'd0},
		// unused code with every other field at its top
		'{FUNC_UNUSED, 32'hFFFF_FFFF, 7'd127, 1'b1, ST_DONE,   1'b0, 7'd2},
		'{FUNC_INSERT, 32'h8000_0000, 7'd64,  1'b0, ST_DONE,   1'b0, 7'd0}
	};

	// Applies one operation to the mirror list and returns the result it should give.
	function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] fn,
			logic [ADDR_W-1:0] a, logic [POS_W-1:0] p);
		list_result_t r;
		int k;
		r = '0;
		r.status = ST_DONE;
		case (fn)
		FUNC_INSERT: begin
			if (mirror_fill >= LIST_DEPTH_DEF) begin
				r.status = ST_FULL;
			end else begin
				mirror_list[mirror_fill] = a;
				mirror_fill++;
			end
		end
		FUNC_DELETE: begin
			if (p == 0 || int'(p) > mirror_fill) begin
				r.status = ST_BADPOS;
			end else begin
				// close the gap: later entries move one place down
				for (k = int'(p) - 1; k + 1 < mirror_fill; k++)
					mirror_list[k] = mirror_list[k + 1];
				mirror_fill--;
			end
		end
		FUNC_LOOKUP: begin
			for (k = 0; k < mirror_fill; k++)
				if (mirror_list[k] == a)
					r.blocked = 1'b1;
		end
		default: begin
		end
		endcase
		r.count = COUNT_W'(mirror_fill);
		return r;
	endfunction

	// Presents one transaction (called at a falling edge), waits for acceptance,
	// queues its expected result and returns at the next falling edge.
	task automatic push_transaction(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] a,
			logic [POS_W-1:0] p, bit typed, list_result_t typed_res);
		list_result_t pr;
		in_valid = 1'b1;
		func = fn;
		address = a;
		position = p;
		do
			@(posedge clk);
		while (!in_ready);
		pr = apply_list_op(fn, a, p);
		pending_results.push_back(typed ? typed_res : pr);
		case (fn)
		FUNC_INSERT: begin
			n_insert++;
			if (pr.status == ST_FULL)
				n_full++;
		end
		FUNC_DELETE: begin
			n_delete++;
			if (pr.status == ST_BADPOS)
				n_badpos++;
		end
		FUNC_LOOKUP: begin
			n_lookup++;
			if (pr.blocked)
				n_hit++;
		end
		default: n_unused++;
		endcase
		if (mirror_fill == LIST_DEPTH_DEF)
			n_max_fill++;
		@(negedge clk);
	endtask

	// Sender gaps: valid low for a random number of cycles.
	task automatic idle_sender();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// Holds the sender off until every queued result has come back.
	task automatic wait_drained();
		in_valid = 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// One random transaction. Traffic alternates between a growing and a shrinking
	// trend, so the list is filled to the limit and emptied several times; most
	// deletes hit a listed position and half the lookups search a listed address.
	task automatic random_transaction();
		int r, q;
		logic [FUNC_W-1:0] fn;
		logic [ADDR_W-1:0] a;
		logic [POS_W-1:0] p;
		if (grow && mirror_fill == LIST_DEPTH_DEF && $urandom_range(3) == 0)
			grow = 1'b0;
		else if (!grow && mirror_fill == 0 && $urandom_range(3) == 0)
			grow = 1'b1;
		else if ($urandom_range(99) == 0)
			grow = !grow;
		r = $urandom_range(99);
		q = $urandom_range(99);
		a = $urandom;
		p = POS_W'($urandom);
		if (r < (grow ? 55 : 15)) begin
			fn = FUNC_INSERT;
			if (q < 15 && mirror_fill > 0) begin
				// duplicate of a listed address
				a = mirror_list[$urandom_range(mirror_fill - 1)];
			end else if (q < 25) begin
				case ($urandom_range(3))
				0: a = '0;
				1: a = '1;
				2: a = ADDR_W'(1) << $urandom_range(ADDR_W - 1);
				default: a = ~(ADDR_W'(1) << $urandom_range(ADDR_W - 1));
				endcase
			end
		end else if (r < (grow ? 70 : 62)) begin
			fn = FUNC_DELETE;
			if (mirror_fill == 0 || q < 12) begin
				if ($urandom_range(3) == 0)
					p = '0;
				else
					p = POS_W'(mirror_fill + 1 + $urandom_range(126 - mirror_fill));
			end else if (q < 25) begin
				p = POS_W'(1);
			end else if (q < 38) begin
				p = POS_W'(mirror_fill);
			end else begin
				p = POS_W'($urandom_range(mirror_fill, 1));
			end
		end else if (r < 96) begin
			fn = FUNC_LOOKUP;
			if (q < 50 && mirror_fill > 0)
				a = mirror_list[$urandom_range(mirror_fill - 1)];
			else if (q < 60 && mirror_fill > 0)
				a = mirror_list[$urandom_range(mirror_fill - 1)] ^
					(ADDR_W'(1) << $urandom_range(ADDR_W - 1));
		end else begin
			fn = FUNC_UNUSED;
		end
		push_transaction(fn, a, p, 1'b0, '0);
	endtask

	// Receiver stalls, redrawn every falling edge.
	always @(negedge clk)
		out_ready = (int'($urandom_range(99)) >= recv_idle_pct);

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending: status %0d blocked %0d count %0d",
					status, blocked, entry_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (blocked !== want.blocked) begin
					$error("blocked: expected %0d, got %0d", want.blocked, blocked);
					mismatches++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					mismatches++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		list_result_t typed_res;
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_INSERT;
		address = '0;
		position = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows, back to back with the receiver always ready.
		foreach (dir_rows[i]) begin
			typed_res.status = dir_rows[i].st;
			typed_res.blocked = dir_rows[i].hit;
			typed_res.count = dir_rows[i].cnt;
			push_transaction(dir_rows[i].fn, dir_rows[i].addr, dir_rows[i].pos,
				dir_rows[i].typed, typed_res);
		end

		// Random phases: receiver-heavy idling, then sender-heavy, then none.
		// Each phase opens with the sender held off until the block has drained.
		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 75 : 0;
			recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 36 : 0;
			grow = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				idle_sender();
				random_transaction();
			end
		end
		in_valid = 1'b0;

		// Drain with a bound, then let trailing cycles expose any extra result.
		waited = 0;
		while (pending_results.size() != 0 && waited < 50 * WORST_LATENCY) begin
			@(negedge clk);
			waited++;
		end
		repeat (WORST_LATENCY) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end

		$display("Covered %0d inserts (%0d refused full), %0d deletes (%0d bad position),",
			n_insert, n_full, n_delete, n_badpos);
		$display("%0d lookups (%0d hits), %0d unused codes; %0d results checked, %0d at full list",
			n_lookup, n_hit, n_unused, results_seen, n_max_fill);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: its time limit is far above the slowest passing run.
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
